// ===== rtl/weighted_jacobi_stencil_sweep_macros.svh =====
// Assertion shorthands for the stencil sweep checkers.
// Each expects clk and rst_n in scope.
`ifndef WEIGHTED_JACOBI_STENCIL_SWEEP_MACROS_SVH
`define WEIGHTED_JACOBI_STENCIL_SWEEP_MACROS_SVH

// Consequent holds in the same cycle, checked outside reset.
`define WJS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stencil sweep port check failed");

// Consequent holds in the next cycle, checked outside reset.
`define WJS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stencil sweep port check failed");

// Consequent holds in the next cycle, checked during reset as well.
`define WJS_ASSERT_ALWAYS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("stencil sweep reset check failed");

`endif

// ===== rtl/wjs_pkg.sv =====
package wjs_pkg;

  localparam int MESH_ROWS = 16;
  localparam int MESH_COLS = 16;

  localparam int ROW_W     = $clog2(MESH_ROWS);
  localparam int COL_W     = $clog2(MESH_COLS);
  localparam int VAL_W     = 16;
  localparam int RF_W      = 15;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  // four neighbors minus four times the center
  localparam int DIFF_W    = VAL_W + 3;
  localparam int PROD_W    = DIFF_W + RF_W + 1;
  localparam int SUM_W     = VAL_W + 4;
  localparam int FRAC_SHIFT = 16;

  localparam logic [COL_W-1:0] COL_ONE       = COL_W'(1);
  localparam logic [COL_W-1:0] COL_LAST      = COL_W'(MESH_COLS - 1);
  localparam logic [COL_W-1:0] COL_PREV_LAST = COL_W'(MESH_COLS - 2);
  localparam logic [ROW_W-1:0] ROW_ONE       = ROW_W'(1);
  localparam logic [ROW_W-1:0] ROW_LAST      = ROW_W'(MESH_ROWS - 1);

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (FRAC_SHIFT - 1));
  localparam logic signed [SUM_W-1:0]  SAT_MAX  = SUM_W'((1 << (VAL_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0]  SAT_MIN  = -SUM_W'(1 << (VAL_W - 1));

  localparam logic signed [VAL_W-1:0] LEFT_PLATE_RST   = 16'sd10240;
  localparam logic signed [VAL_W-1:0] RIGHT_PLATE_RST  = -16'sd10240;
  localparam logic [RF_W-1:0]         RELAX_FACTOR_RST = 15'd24417;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_PLATE,
    CFG_RIGHT_PLATE,
    CFG_RELAX_FACTOR
  } cfg_reg_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] cell_value;
    logic                    grid_start;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_value;
    logic [VAL_W-1:0]        change;
    logic [IDX_W-1:0]        cell_row;
    logic [IDX_W-1:0]        cell_col;
    logic                    grid_done;
  } out_item_t;

  // one column of both line buffers
  typedef struct packed {
    logic signed [VAL_W-1:0] up;
    logic signed [VAL_W-1:0] mid;
  } line_pair_t;

  // operands handed from the line ring to the arithmetic pipeline
  typedef struct packed {
    logic signed [VAL_W-1:0]  v;
    logic signed [DIFF_W-1:0] d;
    logic                     plate_sel;
    logic signed [VAL_W-1:0]  plate;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     done;
  } relax_op_t;

endpackage

// ===== rtl/wjs_cell.sv =====
module wjs_cell (
  input  logic                clk,
  input  logic                shift,
  input  wjs_pkg::line_pair_t nb_in,
  output wjs_pkg::line_pair_t pair_q
);

  wjs_pkg::line_pair_t pair_r;

  // advance one place toward the head of the ring
  always_ff @(posedge clk) begin
    if (shift) begin
      pair_r <= nb_in;
    end
  end

  assign pair_q = pair_r;

endmodule

// ===== rtl/wjs_relax.sv =====
module wjs_relax (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          op_valid,
  output logic                          op_ready,
  input  wjs_pkg::relax_op_t            op,
  input  logic [wjs_pkg::RF_W-1:0]      relax_factor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wjs_pkg::out_item_t            out_data
);

  logic                                 p_valid_r;
  wjs_pkg::relax_op_t                   p_op_r;
  logic signed [wjs_pkg::PROD_W-1:0]    p_prod_r;
  logic signed [wjs_pkg::PROD_W-1:0]    p_prod_nxt;

  logic                                 n_valid_r;
  wjs_pkg::relax_op_t                   n_op_r;
  logic signed [wjs_pkg::VAL_W-1:0]     n_value_r;
  logic signed [wjs_pkg::VAL_W-1:0]     n_value_nxt;

  logic                                 o_valid_r;
  wjs_pkg::out_item_t                   o_data_r;
  wjs_pkg::out_item_t                   o_data_nxt;

  logic signed [wjs_pkg::PROD_W-1:0]    rounded;
  logic signed [wjs_pkg::PROD_W-1:0]    q_full;
  logic signed [wjs_pkg::SUM_W-1:0]     sum;
  logic signed [wjs_pkg::VAL_W:0]       diff;
  logic [wjs_pkg::VAL_W:0]              diff_abs;

  logic p_en, n_en, o_en;

  // each stage moves when the one after it is empty or moving
  assign o_en     = !o_valid_r || out_ready;
  assign n_en     = !n_valid_r || o_en;
  assign p_en     = !p_valid_r || n_en;
  assign op_ready = p_en;

  assign p_prod_nxt = op.d * $signed({1'b0, relax_factor});

  always_comb begin
    rounded = p_prod_r + wjs_pkg::RND_HALF;
    q_full  = rounded >>> wjs_pkg::FRAC_SHIFT;
    sum     = wjs_pkg::SUM_W'(p_op_r.v) + q_full[wjs_pkg::SUM_W-1:0];
    priority if (p_op_r.plate_sel) begin
      n_value_nxt = p_op_r.plate;
    end else if (sum > wjs_pkg::SAT_MAX) begin
      n_value_nxt = wjs_pkg::SAT_MAX[wjs_pkg::VAL_W-1:0];
    end else if (sum < wjs_pkg::SAT_MIN) begin
      n_value_nxt = wjs_pkg::SAT_MIN[wjs_pkg::VAL_W-1:0];
    end else begin
      n_value_nxt = sum[wjs_pkg::VAL_W-1:0];
    end
  end

  always_comb begin
    diff     = {n_op_r.v[wjs_pkg::VAL_W-1], n_op_r.v}
             - {n_value_r[wjs_pkg::VAL_W-1], n_value_r};
    diff_abs = diff[wjs_pkg::VAL_W] ? -diff : diff;
    o_data_nxt.new_value = n_value_r;
    o_data_nxt.change    = diff_abs[wjs_pkg::VAL_W-1:0];
    o_data_nxt.cell_row  = n_op_r.row;
    o_data_nxt.cell_col  = n_op_r.col;
    o_data_nxt.grid_done = n_op_r.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      n_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (p_en) begin
        p_valid_r <= op_valid;
      end
      if (n_en) begin
        n_valid_r <= p_valid_r;
      end
      if (o_en) begin
        o_valid_r <= n_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_en) begin
      p_op_r   <= op;
      p_prod_r <= p_prod_nxt;
    end
    if (n_en) begin
      n_op_r    <= p_op_r;
      n_value_r <= n_value_nxt;
    end
    if (o_en) begin
      o_data_r <= o_data_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

endmodule

// ===== rtl/weighted_jacobi_stencil_sweep.sv =====
// One weighted-Jacobi sweep of the 5-point Laplace stencil over a streamed grid.
// Input channel (in_valid/in_ready/in_data): old cells in row-major order, Q4.12;
// grid_start marks cell (0,0) of a grid. Result channel (out_valid/out_ready/
// out_data): relaxed cells with their absolute change and position, one row
// behind the input; grid_done flags the last cell of the grid.
// Throughput: one item per cycle while the receiver keeps up and no drain or
// ring turn holds input off. Cell (r,c) is offered on out once the item for
// (r+1,c) has passed the operand, product, round/saturate and output registers.
// Row 0 items give no result. After the last grid item the last row is drained
// from the line ring while input is held off; a grid_start arriving mid-row
// holds input while the ring turns back to column 0. Configuration writes
// (cfg_we/cfg_index/cfg_wdata) take effect at once; the user makes them while
// the block is idle (not enforced by the block); unknown indexes are dropped.
// Reset clears the position, the pipeline valids and the configuration to its
// defaults; line contents are not cleared. When the receiver stalls, the
// pipeline stages fill and in_ready falls once the operand register backs up.
module weighted_jacobi_stencil_sweep (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wjs_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wjs_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [wjs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wjs_pkg::CFG_W-1:0]         cfg_wdata
);

  logic signed [wjs_pkg::VAL_W-1:0] left_plate_r;
  logic signed [wjs_pkg::VAL_W-1:0] right_plate_r;
  logic [wjs_pkg::RF_W-1:0]         relax_factor_r;

  wjs_pkg::state_t           state_r, state_nxt;
  logic [wjs_pkg::ROW_W-1:0] row_r, row_nxt, row_eff;
  logic [wjs_pkg::COL_W-1:0] head_r, head_nxt;

  // the ring: cell 0 always holds the column at head_r
  wjs_pkg::line_pair_t cell_q [wjs_pkg::MESH_COLS];
  wjs_pkg::line_pair_t tail_in;
  logic                rotate;

  logic align_need, spin, accept, flush_emit, gen_valid;

  logic                s1_valid_r;
  wjs_pkg::relax_op_t  s1_r, s1_nxt;
  logic                s1_en, relax_ready;

  logic signed [wjs_pkg::VAL_W-1:0] up_op, dn_op, lf_nb, lf_op, rt_op, v_op;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_plate_r   <= wjs_pkg::LEFT_PLATE_RST;
      right_plate_r  <= wjs_pkg::RIGHT_PLATE_RST;
      relax_factor_r <= wjs_pkg::RELAX_FACTOR_RST;
    end else if (cfg_we) begin
      unique case (wjs_pkg::cfg_reg_t'(cfg_index))
        wjs_pkg::CFG_LEFT_PLATE: begin
          left_plate_r <= cfg_wdata[wjs_pkg::VAL_W-1:0];
        end
        wjs_pkg::CFG_RIGHT_PLATE: begin
          right_plate_r <= cfg_wdata[wjs_pkg::VAL_W-1:0];
        end
        wjs_pkg::CFG_RELAX_FACTOR: begin
          relax_factor_r <= cfg_wdata[wjs_pkg::RF_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // a new grid restarts at row 0; the ring must first turn to column 0
  assign row_eff    = in_data.grid_start ? '0 : row_r;
  assign align_need = in_valid && in_data.grid_start && (head_r != '0);
  assign s1_en      = !s1_valid_r || relax_ready;

  // FSM outputs
  always_comb begin
    in_ready   = 1'b0;
    flush_emit = 1'b0;
    spin       = 1'b0;
    unique case (state_r)
      wjs_pkg::ST_RUN: begin
        in_ready = s1_en && !align_need;
        spin     = align_need;
      end
      wjs_pkg::ST_FLUSH: begin
        flush_emit = s1_en;
      end
    endcase
  end

  assign accept = in_valid && in_ready;
  assign rotate = accept || flush_emit || spin;

  // FSM next state: drain the last row after the final grid item
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wjs_pkg::ST_RUN: begin
        if (accept && head_r == wjs_pkg::COL_LAST && row_eff == wjs_pkg::ROW_LAST) begin
          state_nxt = wjs_pkg::ST_FLUSH;
        end
      end
      wjs_pkg::ST_FLUSH: begin
        if (flush_emit && head_r == wjs_pkg::COL_LAST) begin
          state_nxt = wjs_pkg::ST_RUN;
        end
      end
    endcase
  end

  // position: head follows the ring, row advances at the end of each row
  always_comb begin
    head_nxt = head_r;
    if (rotate) begin
      head_nxt = (head_r == wjs_pkg::COL_LAST) ? '0 : head_r + wjs_pkg::COL_ONE;
    end
    row_nxt = row_r;
    if (accept) begin
      if (head_r == wjs_pkg::COL_LAST) begin
        row_nxt = (row_eff == wjs_pkg::ROW_LAST) ? '0 : row_eff + wjs_pkg::ROW_ONE;
      end else begin
        row_nxt = row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wjs_pkg::ST_RUN;
      row_r   <= '0;
      head_r  <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      head_r  <= head_nxt;
    end
  end

  // on an accepted item the head column moves its middle value up and takes
  // the new cell; otherwise the column goes around unchanged
  always_comb begin
    tail_in = cell_q[0];
    if (accept) begin
      tail_in.up  = cell_q[0].mid;
      tail_in.mid = in_data.cell_value;
    end
  end

  for (genvar k = 0; k < wjs_pkg::MESH_COLS; k++) begin : g_ring
    if (k == wjs_pkg::MESH_COLS - 1) begin : g_tail
      wjs_cell u_cell (
        .clk    (clk),
        .shift  (rotate),
        .nb_in  (tail_in),
        .pair_q (cell_q[k])
      );
    end else begin : g_body
      wjs_cell u_cell (
        .clk    (clk),
        .shift  (rotate),
        .nb_in  (cell_q[k+1]),
        .pair_q (cell_q[k])
      );
    end
  end

  // stencil operands: cell 0 is the center column, the tail cell the column
  // to its left (old values, not relaxed ones), cell 1 the column to its right
  always_comb begin
    v_op = cell_q[0].mid;
    if (state_r == wjs_pkg::ST_FLUSH) begin
      up_op = cell_q[0].up;
      dn_op = '0;
      lf_nb = cell_q[wjs_pkg::MESH_COLS-1].mid;
    end else begin
      up_op = (row_eff == wjs_pkg::ROW_ONE) ? '0 : cell_q[0].up;
      dn_op = in_data.cell_value;
      lf_nb = cell_q[wjs_pkg::MESH_COLS-1].up;
    end
    lf_op = (head_r == wjs_pkg::COL_ONE) ? left_plate_r : lf_nb;
    rt_op = (head_r == wjs_pkg::COL_PREV_LAST) ? right_plate_r : cell_q[1].mid;

    s1_nxt.v         = v_op;
    s1_nxt.d         = wjs_pkg::DIFF_W'(up_op) + wjs_pkg::DIFF_W'(dn_op)
                     + wjs_pkg::DIFF_W'(lf_op) + wjs_pkg::DIFF_W'(rt_op)
                     - (wjs_pkg::DIFF_W'(v_op) <<< 2);
    s1_nxt.plate_sel = (head_r == '0) || (head_r == wjs_pkg::COL_LAST);
    s1_nxt.plate     = (head_r == '0) ? left_plate_r : right_plate_r;
    s1_nxt.row       = (state_r == wjs_pkg::ST_FLUSH)
                     ? wjs_pkg::IDX_W'(wjs_pkg::ROW_LAST)
                     : wjs_pkg::IDX_W'(row_eff - wjs_pkg::ROW_ONE);
    s1_nxt.col       = wjs_pkg::IDX_W'(head_r);
    s1_nxt.done      = (state_r == wjs_pkg::ST_FLUSH) && (head_r == wjs_pkg::COL_LAST);

    // row 0 items only fill the ring
    gen_valid = flush_emit || (accept && (row_eff != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= gen_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_r <= s1_nxt;
    end
  end

  wjs_relax u_relax (
    .clk          (clk),
    .rst_n        (rst_n),
    .op_valid     (s1_valid_r),
    .op_ready     (relax_ready),
    .op           (s1_r),
    .relax_factor (relax_factor_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// ===== rtl/wjs_port_checker.sv =====
`include "weighted_jacobi_stencil_sweep_macros.svh"

module wjs_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input wjs_pkg::out_item_t out_data
);

  localparam logic [wjs_pkg::IDX_W-1:0] LAST_COL = wjs_pkg::IDX_W'(wjs_pkg::MESH_COLS - 1);
  localparam logic [wjs_pkg::IDX_W-1:0] LAST_ROW = wjs_pkg::IDX_W'(wjs_pkg::MESH_ROWS - 1);

  // a stalled result holds
  `WJS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // the grid end flag sits only on the bottom-right cell
  `WJS_ASSERT_NOW(a_done_pos, out_valid && out_data.grid_done, (out_data.cell_col == LAST_COL) && (out_data.cell_row == LAST_ROW))

  // the next grid gives nothing until its second row arrives
  `WJS_ASSERT_NEXT(a_done_gap, out_valid && out_ready && out_data.grid_done, !out_valid)

  // reset drops any pending result
  `WJS_ASSERT_ALWAYS_NEXT(a_rst_clear, !rst_n, !out_valid)

endmodule

bind weighted_jacobi_stencil_sweep wjs_port_checker u_port_checker (.*);
